### sv/mlm_pkg.sv
// Shared constants, types and register codes of the multi-pattern line matcher.
package mlm_pkg;

   localparam int NUM_SLOTS     = 4;
   localparam int PATTERN_BYTES = 8;
   localparam int SLOT_MAX      = 4;

   localparam int BYTE_W     = 8;
   localparam int PATTERN_W  = 64;
   localparam int LEN_W      = 4;
   localparam int RES_W      = 3;
   localparam int DATA_W     = 64;
   localparam int ADDR_W     = 6;
   localparam int ADDR_LSB   = 3;
   localparam int HIST_DEPTH = (PATTERN_BYTES > 1) ? PATTERN_BYTES - 1 : 1;
   localparam int WIN_W      = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
   localparam int CNT_W      = $clog2(PATTERN_BYTES + 1);

   typedef enum logic [ADDR_W-ADDR_LSB-1:0] {
      REG_PATTERN_A = 3'd0,
      REG_PATTERN_B = 3'd1,
      REG_PATTERN_C = 3'd2,
      REG_PATTERN_D = 3'd3,
      REG_LENGTH_A  = 3'd4,
      REG_LENGTH_B  = 3'd5,
      REG_LENGTH_C  = 3'd6,
      REG_LENGTH_D  = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [SLOT_MAX-1:0][PATTERN_W-1:0] pattern;
      logic [SLOT_MAX-1:0][LEN_W-1:0]     length;
   } cfg_type;

endpackage

### sv/multi_pattern_line_matcher_top.sv
// Multi-pattern line matcher: input register, slot compare, result register.
// Takes one line byte per cycle and reports, on the byte marked end of line,
// the lowest slot (plus one) whose pattern occurred in the line, or 0. A byte
// waits in the input register and is compared against all slots at once as
// it leaves it; as an end-of-line byte leaves, its result is loaded into the
// output register. Sustained rate is one byte per cycle; the input stalls only when
// an end-of-line byte is ready while the previous result is still waiting.
module multi_pattern_line_matcher_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mlm_pkg::BYTE_W-1:0]    req_line_byte,
   input  logic                          req_end_of_line,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mlm_pkg::RES_W-1:0]     rsp_match_slot,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mlm_pkg::ADDR_W-1:0]    paddr,
   input  logic [mlm_pkg::DATA_W-1:0]    pwdata,
   output logic [mlm_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   mlm_pkg::cfg_type             cfg;
   logic                         in_valid_ff, in_valid_in;
   logic [mlm_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                         in_eol_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [mlm_pkg::RES_W-1:0]    rsp_slot_ff;
   logic [mlm_pkg::RES_W-1:0]    match_slot;
   logic                         s1_move, req_accept, rsp_load;

   assign pready = 1'b1;

   mlm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   mlm_core u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (s1_move),
      .line_byte   (in_byte_ff),
      .end_of_line (in_eol_ff),
      .cfg         (cfg),
      .match_slot  (match_slot)
   );

   assign s1_move    = in_valid_ff && !(in_eol_ff && rsp_valid_ff && rsp_stall);
   assign req_stall  = in_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = s1_move && in_eol_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (s1_move) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_line_byte;
         in_eol_ff  <= req_end_of_line;
      end
      if (rsp_load) begin
         rsp_slot_ff <= match_slot;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_match_slot = rsp_slot_ff;

`ifndef SYNTH
   a_stall_only_on_eol: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_eol_ff && rsp_valid_ff))
      else $error("input stalled without a blocked end-of-line transaction");

   a_eol_gives_result: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("end-of-line transaction did not produce a result");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_slot_ff <= mlm_pkg::RES_W'(mlm_pkg::NUM_SLOTS)))
      else $error("result slot out of range");
`endif

endmodule

### sv/mlm_csr.sv
// Configuration registers: pattern bytes and lengths of every slot.
module mlm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mlm_pkg::ADDR_W-1:0]    paddr,
   input  logic [mlm_pkg::DATA_W-1:0]    pwdata,
   output logic [mlm_pkg::DATA_W-1:0]    prdata,
   output mlm_pkg::cfg_type              cfg
);

   logic [mlm_pkg::SLOT_MAX-1:0][mlm_pkg::PATTERN_W-1:0] pattern_ff, pattern_in;
   logic [mlm_pkg::SLOT_MAX-1:0][mlm_pkg::LEN_W-1:0]     length_ff, length_in;
   mlm_pkg::reg_index_type                               index;
   logic                                                 write_en;

   assign index    = mlm_pkg::reg_index_type'(paddr[mlm_pkg::ADDR_W-1:mlm_pkg::ADDR_LSB]);
   assign write_en = psel & penable & pwrite;

   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      if (write_en) begin
         unique case (index)
            mlm_pkg::REG_PATTERN_A: pattern_in[0] = pwdata;
            mlm_pkg::REG_PATTERN_B: pattern_in[1] = pwdata;
            mlm_pkg::REG_PATTERN_C: pattern_in[2] = pwdata;
            mlm_pkg::REG_PATTERN_D: pattern_in[3] = pwdata;
            mlm_pkg::REG_LENGTH_A:  length_in[0]  = pwdata[mlm_pkg::LEN_W-1:0];
            mlm_pkg::REG_LENGTH_B:  length_in[1]  = pwdata[mlm_pkg::LEN_W-1:0];
            mlm_pkg::REG_LENGTH_C:  length_in[2]  = pwdata[mlm_pkg::LEN_W-1:0];
            mlm_pkg::REG_LENGTH_D:  length_in[3]  = pwdata[mlm_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= '0;
      end else begin
         pattern_ff <= pattern_in;
         length_ff  <= length_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (index)
         mlm_pkg::REG_PATTERN_A: prdata = pattern_ff[0];
         mlm_pkg::REG_PATTERN_B: prdata = pattern_ff[1];
         mlm_pkg::REG_PATTERN_C: prdata = pattern_ff[2];
         mlm_pkg::REG_PATTERN_D: prdata = pattern_ff[3];
         mlm_pkg::REG_LENGTH_A:  prdata = mlm_pkg::DATA_W'(length_ff[0]);
         mlm_pkg::REG_LENGTH_B:  prdata = mlm_pkg::DATA_W'(length_ff[1]);
         mlm_pkg::REG_LENGTH_C:  prdata = mlm_pkg::DATA_W'(length_ff[2]);
         mlm_pkg::REG_LENGTH_D:  prdata = mlm_pkg::DATA_W'(length_ff[3]);
         default: ;
      endcase
   end

   assign cfg.pattern = pattern_ff;
   assign cfg.length  = length_ff;

endmodule

### sv/mlm_core.sv
// Line state and parallel pattern compare of all slots against the byte window.
module mlm_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [mlm_pkg::BYTE_W-1:0]    line_byte,
   input  logic                          end_of_line,
   input  mlm_pkg::cfg_type              cfg,
   output logic [mlm_pkg::RES_W-1:0]     match_slot
);

   logic [mlm_pkg::BYTE_W-1:0] hist_ff [mlm_pkg::HIST_DEPTH];
   logic [mlm_pkg::BYTE_W-1:0] hist_in [mlm_pkg::HIST_DEPTH];
   logic [mlm_pkg::BYTE_W-1:0] win [mlm_pkg::PATTERN_BYTES];
   logic [mlm_pkg::CNT_W-1:0]  count_ff, count_in, seen_now;
   logic [mlm_pkg::NUM_SLOTS-1:0] hit_ff, hit_in, hit_now, hits_all;
   logic [mlm_pkg::LEN_W-1:0]  len_c [mlm_pkg::NUM_SLOTS];

   // win[0] is the byte in hand, win[k] the byte k steps older
   always_comb begin
      win[0] = line_byte;
      for (int k = 1; k < mlm_pkg::PATTERN_BYTES; k++) begin
         win[k] = hist_ff[k-1];
      end
   end

   assign seen_now = (count_ff == mlm_pkg::CNT_W'(mlm_pkg::PATTERN_BYTES))
                   ? count_ff : count_ff + mlm_pkg::CNT_W'(1);

   always_comb begin
      for (int s = 0; s < mlm_pkg::NUM_SLOTS; s++) begin
         len_c[s] = (cfg.length[s] > mlm_pkg::LEN_W'(mlm_pkg::PATTERN_BYTES))
                  ? mlm_pkg::LEN_W'(mlm_pkg::PATTERN_BYTES) : cfg.length[s];
      end
   end

   // pattern byte i lines up with the byte (len-1-i) steps old
   always_comb begin
      logic [mlm_pkg::LEN_W-1:0] age;
      for (int s = 0; s < mlm_pkg::NUM_SLOTS; s++) begin
         hit_now[s] = (len_c[s] != '0) && (mlm_pkg::LEN_W'(seen_now) >= len_c[s]);
         for (int i = 0; i < mlm_pkg::PATTERN_BYTES; i++) begin
            age = len_c[s] - mlm_pkg::LEN_W'(i) - mlm_pkg::LEN_W'(1);
            if ((mlm_pkg::LEN_W'(i) < len_c[s]) &&
                (win[age[mlm_pkg::WIN_W-1:0]] != cfg.pattern[s][mlm_pkg::BYTE_W*i +: 8])) begin
               hit_now[s] = 1'b0;
            end
         end
      end
   end

   assign hits_all = hit_ff | hit_now;

   always_comb begin
      match_slot = '0;
      for (int s = mlm_pkg::NUM_SLOTS - 1; s >= 0; s--) begin
         if (hits_all[s]) begin
            match_slot = mlm_pkg::RES_W'(s + 1);
         end
      end
   end

   always_comb begin
      hist_in[0] = line_byte;
      for (int k = 1; k < mlm_pkg::HIST_DEPTH; k++) begin
         hist_in[k] = hist_ff[k-1];
      end
      count_in = seen_now;
      hit_in   = hits_all;
      if (end_of_line) begin
         for (int k = 0; k < mlm_pkg::HIST_DEPTH; k++) begin
            hist_in[k] = '0;
         end
         count_in = '0;
         hit_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < mlm_pkg::HIST_DEPTH; k++) begin
            hist_ff[k] <= '0;
         end
         count_ff <= '0;
         hit_ff   <= '0;
      end else if (advance) begin
         hist_ff  <= hist_in;
         count_ff <= count_in;
         hit_ff   <= hit_in;
      end
   end

endmodule

### verif/tb_top.sv
// Self-checking testbench for the multi-pattern line matcher: directed and random lines, APB setup.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [mlm_pkg::BYTE_W-1:0] line_byte;
      logic                       end_of_line;
   } line_item_type;

   localparam int QUIET_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 150;

   logic                         clock           = 1'b0;
   logic                         reset           = 1'b1;
   logic                         req_valid       = 1'b0;
   logic                         req_stall;
   logic [mlm_pkg::BYTE_W-1:0]   req_line_byte   = '0;
   logic                         req_end_of_line = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall       = 1'b0;
   logic [mlm_pkg::RES_W-1:0]    rsp_match_slot;
   logic                         psel            = 1'b0;
   logic                         penable         = 1'b0;
   logic                         pwrite          = 1'b0;
   logic [mlm_pkg::ADDR_W-1:0]   paddr           = '0;
   logic [mlm_pkg::DATA_W-1:0]   pwdata          = '0;
   logic [mlm_pkg::DATA_W-1:0]   prdata;
   logic                         pready;

   multi_pattern_line_matcher_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_line_byte   (req_line_byte),
      .req_end_of_line (req_end_of_line),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_match_slot  (rsp_match_slot),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   line_item_type              byte_backlog[$];
   line_item_type              in_flight;
   logic [mlm_pkg::RES_W-1:0]  match_slot_due[$];
   int                         sender_idle_pct    = 0;
   int                         receiver_stall_pct = 0;
   int                         fail_count         = 0;
   int                         quiet_cycles       = 0;
   int                         items_queued       = 0;

   // line matcher state as the testbench sees it
   logic [mlm_pkg::PATTERN_W-1:0] gold_pattern [mlm_pkg::SLOT_MAX];
   logic [mlm_pkg::LEN_W-1:0]     gold_length  [mlm_pkg::SLOT_MAX];
   logic [mlm_pkg::BYTE_W-1:0]    gold_hist    [mlm_pkg::HIST_DEPTH];
   int                            gold_seen;
   bit                            gold_hit     [mlm_pkg::SLOT_MAX];

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic void clear_line();
      foreach (gold_hist[j]) gold_hist[j] = '0;
      gold_seen = 0;
      foreach (gold_hit[s]) gold_hit[s] = 1'b0;
   endfunction

   task automatic score_byte(input line_item_type it);
      logic [mlm_pkg::BYTE_W-1:0] win [mlm_pkg::PATTERN_BYTES];
      int                         len;
      bit                         ok;
      logic [mlm_pkg::RES_W-1:0]  slot_id;
      win[mlm_pkg::PATTERN_BYTES-1] = it.line_byte;
      for (int j = 1; j < mlm_pkg::PATTERN_BYTES; j++)
         win[mlm_pkg::PATTERN_BYTES-1-j] = gold_hist[j-1];
      if (gold_seen < mlm_pkg::PATTERN_BYTES) gold_seen++;
      for (int s = 0; s < mlm_pkg::NUM_SLOTS && s < mlm_pkg::SLOT_MAX; s++) begin
         len = (gold_length[s] > mlm_pkg::PATTERN_BYTES) ? mlm_pkg::PATTERN_BYTES
                                                         : int'(gold_length[s]);
         if (len != 0 && gold_seen >= len) begin
            ok = 1'b1;
            for (int i = 0; i < len; i++)
               if (win[mlm_pkg::PATTERN_BYTES-len+i] != gold_pattern[s][8*i +: 8]) ok = 1'b0;
            if (ok) gold_hit[s] = 1'b1;
         end
      end
      for (int j = mlm_pkg::HIST_DEPTH - 1; j > 0; j--) gold_hist[j] = gold_hist[j-1];
      gold_hist[0] = it.line_byte;
      if (it.end_of_line) begin
         slot_id = '0;
         for (int s = mlm_pkg::NUM_SLOTS - 1; s >= 0; s--)
            if (s < mlm_pkg::SLOT_MAX && gold_hit[s]) slot_id = mlm_pkg::RES_W'(s + 1);
         match_slot_due.push_back(slot_id);
         clear_line();
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) score_byte(in_flight);
         if (!req_valid || !req_stall) begin
            if (byte_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               in_flight = byte_backlog.pop_front();
               req_valid       <= 1'b1;
               req_line_byte   <= in_flight.line_byte;
               req_end_of_line <= in_flight.end_of_line;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : result_check
      logic [mlm_pkg::RES_W-1:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (match_slot_due.size() == 0) begin
               $error("unexpected transaction: match_slot %0d", rsp_match_slot);
               fail_count++;
            end else begin
               want = match_slot_due.pop_front();
               if (rsp_match_slot !== want) begin
                  $error("match_slot expected %0d actual %0d", want, rsp_match_slot);
                  fail_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic csr_access(input mlm_pkg::reg_index_type idx, input logic wr,
                             input logic [mlm_pkg::DATA_W-1:0] data,
                             output logic [mlm_pkg::DATA_W-1:0] rd);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, {mlm_pkg::ADDR_LSB{1'b0}}};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic configure(input logic [mlm_pkg::PATTERN_W-1:0] pats [mlm_pkg::SLOT_MAX],
                            input logic [mlm_pkg::LEN_W-1:0] lens [mlm_pkg::SLOT_MAX]);
      mlm_pkg::reg_index_type     idx;
      logic [mlm_pkg::DATA_W-1:0] wdata, rdata, want;
      for (int r = 0; r < 2 * mlm_pkg::SLOT_MAX; r++) begin
         idx = mlm_pkg::reg_index_type'(r);
         if (idx < mlm_pkg::REG_LENGTH_A) begin
            wdata           = pats[r];
            gold_pattern[r] = pats[r];
         end else begin
            wdata                             = {$urandom, $urandom};
            wdata[mlm_pkg::LEN_W-1:0]         = lens[r-mlm_pkg::SLOT_MAX];
            gold_length[r-mlm_pkg::SLOT_MAX]  = lens[r-mlm_pkg::SLOT_MAX];
         end
         csr_access(idx, 1'b1, wdata, rdata);
      end
      for (int r = 0; r < 2 * mlm_pkg::SLOT_MAX; r++) begin
         idx = mlm_pkg::reg_index_type'(r);
         if (idx < mlm_pkg::REG_LENGTH_A) want = gold_pattern[r];
         else want = mlm_pkg::DATA_W'(gold_length[r-mlm_pkg::SLOT_MAX]);
         csr_access(idx, 1'b0, '0, rdata);
         if (rdata !== want) begin
            $error("%s expected %h actual %h", idx.name(), want, rdata);
            fail_count++;
         end
      end
   endtask

   task automatic drain();
      while (byte_backlog.size() != 0 || req_valid || match_slot_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_line(input logic [mlm_pkg::BYTE_W-1:0] text [$]);
      line_item_type it;
      foreach (text[i]) begin
         it.line_byte   = text[i];
         it.end_of_line = (i == text.size() - 1);
         byte_backlog.push_back(it);
         items_queued++;
      end
   endtask

   function automatic logic [mlm_pkg::BYTE_W-1:0] pick_byte(
      input bit wide, input logic [mlm_pkg::BYTE_W-1:0] base);
      return wide ? mlm_pkg::BYTE_W'($urandom_range(255))
                  : mlm_pkg::BYTE_W'(base + $urandom_range(3));
   endfunction

   // random filler around an optional (possibly truncated) copy of one slot's pattern
   task automatic queue_line(input int slot, input bit partial, input bit wide,
                             input logic [mlm_pkg::BYTE_W-1:0] base);
      logic [mlm_pkg::BYTE_W-1:0] text [$];
      int                         len, pre, post;
      pre  = $urandom_range(10);
      post = $urandom_range(10);
      for (int i = 0; i < pre; i++) text.push_back(pick_byte(wide, base));
      if (slot >= 0) begin
         len = (gold_length[slot] > mlm_pkg::PATTERN_BYTES) ? mlm_pkg::PATTERN_BYTES
                                                            : int'(gold_length[slot]);
         if (partial && len > 0) len--;
         for (int i = 0; i < len; i++) text.push_back(gold_pattern[slot][8*i +: 8]);
      end
      for (int i = 0; i < post; i++) text.push_back(pick_byte(wide, base));
      if (text.size() == 0) text.push_back(pick_byte(wide, base));
      send_line(text);
   endtask

   initial begin : stimulus
      logic [mlm_pkg::PATTERN_W-1:0] pats [mlm_pkg::SLOT_MAX];
      logic [mlm_pkg::LEN_W-1:0]     lens [mlm_pkg::SLOT_MAX];
      logic [mlm_pkg::BYTE_W-1:0]    base;
      int                            roll, target;
      clear_line();
      foreach (gold_pattern[s]) gold_pattern[s] = '0;
      foreach (gold_length[s]) gold_length[s] = '0;
      while (reset) @(posedge clock);

      // directed lines
      pats = '{64'h6261, 64'h0123_4567_89AB_CDEF, 64'hFF, 64'h0};
      lens = '{4'd2, 4'd8, 4'd1, 4'd15};
      configure(pats, lens);
      send_line('{8'hFF});
      send_line('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      send_line('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      send_line('{8'h61});
      send_line('{8'h62});
      send_line('{8'hEF, 8'hCD, 8'hAB, 8'h89, 8'h67, 8'h45, 8'h23, 8'h01});
      send_line('{8'hFF, 8'h61, 8'h62});
      drain();

      for (int p = 0; p < PHASES; p++) begin
         base = (p == 1) ? 8'hFC : (p == 2) ? 8'h00 : mlm_pkg::BYTE_W'($urandom_range(255));
         for (int s = 0; s < mlm_pkg::SLOT_MAX; s++) begin
            if (p == 0) begin
               pats[s] = {$urandom, $urandom};
               lens[s] = '0;
            end else if (p == 1) begin
               pats[s] = '1;
               lens[s] = (s == 0) ? 4'd15 : (s == 1) ? 4'd8 : mlm_pkg::LEN_W'(s);
            end else if (p == 2) begin
               pats[s] = '0;
               lens[s] = mlm_pkg::LEN_W'(2 * s + 1);
            end else begin
               if ($urandom_range(3) == 0) pats[s] = {$urandom, $urandom};
               else for (int i = 0; i < mlm_pkg::PATTERN_BYTES; i++)
                  pats[s][8*i +: 8] = pick_byte(0, base);
               roll = $urandom_range(99);
               if (roll < 15) lens[s] = '0;
               else if (roll < 30) lens[s] = mlm_pkg::LEN_W'($urandom_range(15, 9));
               else lens[s] = mlm_pkg::LEN_W'($urandom_range(8, 1));
            end
         end
         configure(pats, lens);
         sender_idle_pct    = (p % 4 == 1) ? 77 : (p % 4 == 3) ? 33 : 0;
         receiver_stall_pct = (p % 4 == 2) ? 77 : (p % 4 == 3) ? 33 : 0;
         target = items_queued + PHASE_ITEMS;
         while (items_queued < target) begin
            if ($urandom_range(99) < 60)
               queue_line($urandom_range(mlm_pkg::SLOT_MAX - 1), $urandom_range(3) == 0,
                          $urandom_range(3) == 0, base);
            else
               queue_line(-1, 1'b0, $urandom_range(3) == 0, base);
         end
         drain();
      end

      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

### files.f
sv/mlm_pkg.sv
sv/mlm_csr.sv
sv/mlm_core.sv
sv/multi_pattern_line_matcher_top.sv
verif/tb_top.sv
